### hdl/rs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_pkg
// Shared types and constants of the reversible stack.
// ---------------------------------------------------------------------------
package rs_pkg;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT  = CNT_W'(DEPTH);
    localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_FLIP = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic                     is_empty;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     overflow;
        logic                     underflow;
    } result_t;

    function automatic logic [ADDR_W-1:0] ring_up(input logic [ADDR_W-1:0] i);
        return (i == LAST_ADDR) ? '0 : i + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_down(input logic [ADDR_W-1:0] i);
        return (i == '0) ? LAST_ADDR : i - ADDR_W'(1);
    endfunction

endpackage

### hdl/rs_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_cmd_if / rs_rsp_if
// Valid/ready channels for stack operations and their results.
// ---------------------------------------------------------------------------
interface rs_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface rs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic               is_empty;
    logic [4:0]         entry_count;
    logic               overflow;
    logic               underflow;

    modport source (output valid, output top_value, output is_empty,
                    output entry_count, output overflow, output underflow,
                    input ready);
    modport sink   (input valid, input top_value, input is_empty,
                    input entry_count, input overflow, input underflow,
                    output ready);
endinterface

### hdl/rs_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_store
// Entry memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rs_store (
    input  logic                     clk,
    input  rs_pkg::mem_req_t         req,
    output logic [rs_pkg::DATA_W-1:0] rd_data
);
    import rs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/rs_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_ctrl
// Ring pointers, count and orientation; issues memory accesses and builds
// the result of each request once the top entry has been read.
// ---------------------------------------------------------------------------
module rs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    rs_cmd_if.sink                    cmd,
    output rs_pkg::mem_req_t          mem_req,
    input  logic [rs_pkg::DATA_W-1:0] rd_data,
    output logic                      res_valid,
    output rs_pkg::result_t           res,
    input  logic                      res_taken
);
    import rs_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] front_reg, front_next;
    logic [ADDR_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;
    logic              ovf_reg, ovf_next;
    logic              unf_reg, unf_next;
    logic              bypass_reg, bypass_next;
    logic [DATA_W-1:0] val_reg;
    logic              accept;
    logic              write_en;
    logic [ADDR_W-1:0] write_addr;

    assign accept = cmd.valid && cmd.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (res_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        cmd.ready = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_READ:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    // pointer update
    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        ovf_next    = 1'b0;
        unf_next    = 1'b0;
        bypass_next = 1'b0;
        write_en    = 1'b0;
        write_addr  = front_reg;
        case (func_t'(cmd.func))
            FUNC_PUSH:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    write_en    = 1'b1;
                    bypass_next = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    if (!rev_reg)
                    begin
                        front_next = ring_up(front_reg);
                        write_addr = front_next;
                    end
                    else
                    begin
                        back_next  = ring_down(back_reg);
                        write_addr = back_next;
                    end
                end
            end
            FUNC_POP:
            begin
                if (count_reg == '0)
                begin
                    unf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (!rev_reg)
                    begin
                        front_next = ring_down(front_reg);
                    end
                    else
                    begin
                        back_next = ring_up(back_reg);
                    end
                end
            end
            FUNC_FLIP:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
                rev_next = rev_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_req.wr_en   = accept && write_en;
        mem_req.wr_addr = write_addr;
        mem_req.wr_data = cmd.push_value;
        mem_req.rd_en   = accept;
        mem_req.rd_addr = rev_next ? back_next : front_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= LAST_ADDR;
            back_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
                rev_reg   <= rev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ovf_reg    <= ovf_next;
            unf_reg    <= unf_next;
            bypass_reg <= bypass_next;
            val_reg    <= cmd.push_value;
        end
    end

    // pushed value bypasses the memory read of the same entry
    always_comb
    begin
        if (count_reg == '0)
        begin
            res.top_value = EMPTY_VALUE;
        end
        else if (bypass_reg)
        begin
            res.top_value = val_reg;
        end
        else
        begin
            res.top_value = rd_data;
        end
        res.is_empty    = (count_reg == '0);
        res.entry_count = COUNT_OUT_W'(count_reg);
        res.overflow    = ovf_reg;
        res.underflow   = unf_reg;
    end

endmodule

### hdl/reversible_stack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// reversible_stack
// LIFO stack held in a ring of entries whose order can be flipped in one
// request.
//
// cmd carries one request: func (push, pop, flip, no-op) and push_value.
// rsp returns one result per request: the logical top (-1 when empty),
// is_empty, entry_count and the overflow and underflow flags.
// Pointers are updated and the new top entry is read in the cycle of
// acceptance; the read data returns in the following cycle from the entry
// memory's registered port and goes to the output register. A new request
// is accepted only once the previous result has left the read state.
// The next request is accepted while a result still waits in the output
// register; a stalled receiver holds the result and, once the output
// register and the read stage are both full, cmd.ready stays low.
// Reset empties the stack and clears the orientation; memory contents are
// not cleared, since read data is used only for entries written by a push.
// ---------------------------------------------------------------------------
module reversible_stack (
    input  logic   clk,
    input  logic   rst_n,
    rs_cmd_if.sink   cmd,
    rs_rsp_if.source rsp
);
    import rs_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    logic              res_valid;
    result_t           res;
    logic              res_taken;
    logic              out_valid_reg;
    result_t           out_reg;

    rs_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    rs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_taken (res_taken)
    );

    assign res_taken = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.top_value   = out_reg.top_value;
    assign rsp.is_empty    = out_reg.is_empty;
    assign rsp.entry_count = out_reg.entry_count;
    assign rsp.overflow    = out_reg.overflow;
    assign rsp.underflow   = out_reg.underflow;

endmodule
